/* rtl/core/pipt_pkg.sv */
// ----------------------------------------------------------------------------
// pipt_pkg
// types and constants shared by the point-in-polytope test unit
// ----------------------------------------------------------------------------
package pipt_pkg;

    localparam int VALUE_W = 24;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = 56;
    localparam int FRAC_W  = 16;
    localparam int PLANE_IDX_W = 8;
    localparam int COORD_IDX_W = 3;
    localparam int DIM_CFG_W   = 4;
    localparam int PCNT_CFG_W  = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [1:0] {
        REQ_COEF   = 2'd0,
        REQ_OFFSET = 2'd1,
        REQ_POINT  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMENSIONS  = 1'b0,
        CFG_PLANE_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/point_in_polytope_test_unit.sv */
// ----------------------------------------------------------------------------
// point_in_polytope_test_unit
// half-space test of a point against a stored convex polytope
// ----------------------------------------------------------------------------
// usage: input items load plane coefficients and offsets into two on-chip
// memories, or deliver point coordinates into a small point buffer. the
// coordinate item marked last starts the test; no other item makes a result.
// the cfg channel writes dimensions and plane_count; the user must write them
// only while the block is idle, which the block itself does not enforce.
// cfg_ready is always high. one shared multiply-accumulate walks the
// memories, one read a cycle: each plane reads its offset, then one
// coefficient per coordinate. the walk stops early at the first violating
// plane and is skipped when plane_count is 0. load items and plain
// coordinates are taken one per cycle while in_ready is high.
// in_ready is low while a test runs and until its result has entered the
// output register. a finished result waits in the output register while
// out_ready is low; new items are still taken then, and a second test
// holds its result until the output register frees up.
// reset clears the control state and sets dimensions to 1 and plane_count
// to 0; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module point_in_polytope_test_unit #(
    parameter int MAX_DIM    = 8,
    parameter int MAX_PLANES = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           req_type,
    input  logic [pipt_pkg::PLANE_IDX_W-1:0]     plane_index,
    input  logic [pipt_pkg::COORD_IDX_W-1:0]     coord_index,
    input  logic signed [pipt_pkg::VALUE_W-1:0]  value,
    input  logic                                 last_coord,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 outside,
    output logic [pipt_pkg::PLANE_IDX_W-1:0]     violating_plane,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pipt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pipt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pipt_pkg::*;

    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int STEP_W  = $clog2(MAX_DIM + 1);
    localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W   = $clog2(MAX_PLANES + 1);
    localparam int DEPTH   = MAX_PLANES * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration
    logic [DIM_CFG_W-1:0]  dimensions_reg;
    logic [PCNT_CFG_W-1:0] plane_count_reg;

    // memories and point buffer
    logic signed [VALUE_W-1:0] coef_mem [DEPTH];
    logic signed [VALUE_W-1:0] off_mem  [MAX_PLANES];
    logic signed [VALUE_W-1:0] point_reg [MAX_DIM];

    // control
    state_t            state_reg, state_next;
    logic              issue_on_reg;
    logic [STEP_W-1:0] dims_reg;
    logic [CNT_W-1:0]  planes_reg;
    logic [CNT_W-1:0]  plane_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              s1_valid_reg, s2_valid_reg;
    logic              out_valid_reg;

    // datapath
    logic                      s1_off_reg, s1_last_reg, s1_final_reg;
    logic [CNT_W-1:0]          s1_plane_reg;
    logic signed [VALUE_W-1:0] s1_pt_reg;
    logic signed [VALUE_W-1:0] coef_rd_reg, off_rd_reg;
    logic                      s2_last_reg, s2_final_reg;
    logic [CNT_W-1:0]          s2_plane_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      res_outside_reg;
    logic [PLANE_IDX_W-1:0]    res_plane_reg;
    logic                      outside_reg;
    logic [PLANE_IDX_W-1:0]    violating_plane_reg;

    // combinational
    logic                      in_accept, cfg_accept, start;
    logic                      coef_we, off_we, pt_we;
    logic [ADDR_W-1:0]         coef_waddr, coef_raddr;
    logic [STEP_W-1:0]         dims_lim;
    logic [CNT_W-1:0]          planes_lim;
    logic                      issue, issue_last, issue_final;
    logic [DIM_W-1:0]          k_idx;
    logic signed [PROD_W-1:0]  mul;
    logic signed [ACC_W-1:0]   off_ext, prod_next;
    logic signed [ACC_W-1:0]   sum;
    logic                      hit, finish, flush, out_load;
    logic [CNT_W+PLANE_IDX_W-1:0] hit_plane_ext;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_accept  = in_valid && in_ready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign coef_we = in_accept && (req_type == REQ_COEF)
                     && (32'(plane_index) < MAX_PLANES) && (32'(coord_index) < MAX_DIM);
    assign off_we  = in_accept && (req_type == REQ_OFFSET) && (32'(plane_index) < MAX_PLANES);
    assign pt_we   = in_accept && (req_type == REQ_POINT) && (32'(coord_index) < MAX_DIM);
    assign start   = in_accept && (req_type == REQ_POINT) && last_coord;

    assign coef_waddr = ADDR_W'(32'(plane_index) * MAX_DIM + 32'(coord_index));

    assign dims_lim   = (32'(dimensions_reg) > MAX_DIM) ? STEP_W'(MAX_DIM)
                                                        : STEP_W'(dimensions_reg);
    assign planes_lim = (32'(plane_count_reg) > MAX_PLANES) ? CNT_W'(MAX_PLANES)
                                                            : CNT_W'(plane_count_reg);

    // issue stage: step 0 reads the offset, step k reads coefficient k-1
    assign issue       = (state_reg == ST_RUN) && issue_on_reg;
    assign issue_last  = (step_reg == dims_reg);
    assign issue_final = (plane_reg == planes_reg - CNT_W'(1));
    assign k_idx       = DIM_W'(step_reg - STEP_W'(1));
    assign coef_raddr  = ADDR_W'(base_reg + ADDR_W'(step_reg) - ADDR_W'(1));

    // product stage
    assign mul       = coef_rd_reg * s1_pt_reg;
    assign off_ext   = ACC_W'(off_rd_reg);
    assign prod_next = s1_off_reg ? -(off_ext <<< FRAC_W) : ACC_W'(mul);

    // accumulate and compare stage
    assign sum           = acc_reg + prod_reg;
    assign hit           = s2_valid_reg && s2_last_reg && (sum > 0);
    assign finish        = s2_valid_reg && s2_last_reg && (hit || s2_final_reg);
    assign flush         = (state_reg == ST_RUN) && finish;
    assign hit_plane_ext = {{PLANE_IDX_W{1'b0}}, s2_plane_reg};
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (planes_lim == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimensions_reg  <= DIM_CFG_W'(1);
            plane_count_reg <= '0;
            issue_on_reg    <= 1'b0;
            dims_reg        <= '0;
            planes_reg      <= '0;
            plane_reg       <= '0;
            step_reg        <= '0;
            base_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                unique case (cfg_index)
                    CFG_DIMENSIONS:  dimensions_reg  <= cfg_data[DIM_CFG_W-1:0];
                    CFG_PLANE_COUNT: plane_count_reg <= cfg_data[PCNT_CFG_W-1:0];
                    default:         ;
                endcase
            end

            if (start)
            begin
                dims_reg     <= dims_lim;
                planes_reg   <= planes_lim;
                plane_reg    <= '0;
                step_reg     <= '0;
                base_reg     <= '0;
                issue_on_reg <= (planes_lim != '0);
            end
            else if (flush)
            begin
                issue_on_reg <= 1'b0;
            end
            else if (issue)
            begin
                if (issue_last)
                begin
                    step_reg  <= '0;
                    plane_reg <= plane_reg + CNT_W'(1);
                    base_reg  <= base_reg + ADDR_W'(MAX_DIM);
                    if (issue_final)
                    begin
                        issue_on_reg <= 1'b0;
                    end
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end

            s1_valid_reg <= issue && !flush;
            s2_valid_reg <= s1_valid_reg && !flush;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= value;
        end
        coef_rd_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
        begin
            off_mem[PLANE_W'(plane_index)] <= value;
        end
        off_rd_reg <= off_mem[plane_reg[PLANE_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            point_reg[DIM_W'(coord_index)] <= value;
        end
    end

    // datapath pipeline
    always_ff @(posedge clk)
    begin
        s1_off_reg   <= (step_reg == '0);
        s1_last_reg  <= issue_last;
        s1_final_reg <= issue_final;
        s1_plane_reg <= plane_reg;
        s1_pt_reg    <= point_reg[k_idx];

        prod_reg     <= prod_next;
        s2_last_reg  <= s1_last_reg;
        s2_final_reg <= s1_final_reg;
        s2_plane_reg <= s1_plane_reg;

        if (start || (s2_valid_reg && s2_last_reg))
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= sum;
        end

        if (start)
        begin
            res_outside_reg <= 1'b0;
            res_plane_reg   <= '0;
        end
        else if (flush)
        begin
            res_outside_reg <= hit;
            res_plane_reg   <= hit ? hit_plane_ext[PLANE_IDX_W-1:0] : '0;
        end

        if (out_load)
        begin
            outside_reg         <= res_outside_reg;
            violating_plane_reg <= res_plane_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign outside         = outside_reg;
    assign violating_plane = violating_plane_reg;

endmodule

/* test/tb_point_in_polytope_test_unit.sv */
// ----------------------------------------------------------------------------
// tb_point_in_polytope_test_unit
// self-checking bench for the point-in-polytope test unit
// ----------------------------------------------------------------------------
// loads plane coefficients and offsets, then sends points one coordinate per
// item. a local half-space evaluator predicts the outside flag and the first
// violating plane for every point, and the monitor compares each result with
// the oldest prediction. a directed opening covers boundary points, extreme
// values, stray request codes, zero planes and zero dimensions; random
// phases then sweep the register settings, with random gaps on both sides
// and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_in_polytope_test_unit;

    import pipt_pkg::*;

    localparam int MAX_DIM      = 8;
    localparam int MAX_PLANES   = 256;
    localparam int IDLE_PCT     = 37;
    localparam int HOLD_CYCLES  = 700;
    localparam int HOLD_AFTER   = 40;
    localparam int SETTLE       = 16;
    localparam int DRAIN_CYCLES = MAX_PLANES * (MAX_DIM + 1) + 8;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;
    localparam logic signed [VALUE_W-1:0] ONE       = 24'sh010000;

    typedef enum int {MIX_NARROW, MIX_FULL} value_mix_t;

    typedef struct {
        req_t                       kind;
        logic [PLANE_IDX_W-1:0]     plane;
        logic [COORD_IDX_W-1:0]     coord;
        logic signed [VALUE_W-1:0]  val;
        logic                       last;
    } request_t;

    typedef struct packed {
        logic                    outside;
        logic [PLANE_IDX_W-1:0]  plane;
    } verdict_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     req_type = '0;
    logic [PLANE_IDX_W-1:0]         plane_index = '0;
    logic [COORD_IDX_W-1:0]         coord_index = '0;
    logic signed [VALUE_W-1:0]      value = '0;
    logic                           last_coord = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           outside;
    logic [PLANE_IDX_W-1:0]         violating_plane;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;

    // stimulus side
    request_t  request_q[$];
    bit        coef_loaded [MAX_PLANES * MAX_DIM];
    bit        offset_loaded [MAX_PLANES];
    bit        coord_loaded [MAX_DIM];
    int        in_gap_pct = IDLE_PCT;
    int        out_gap_pct = IDLE_PCT;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    bit        in_fire = 1'b0;

    // evaluator copy of the block
    logic signed [VALUE_W-1:0]  coef_tab [MAX_PLANES * MAX_DIM];
    logic signed [VALUE_W-1:0]  offset_tab [MAX_PLANES];
    logic signed [VALUE_W-1:0]  point_buf [MAX_DIM];
    logic [DIM_CFG_W-1:0]       dims_reg = 4'd1;
    logic [PCNT_CFG_W-1:0]      planes_reg = '0;
    verdict_t                   verdict_q[$];
    int                         verdicts_seen = 0;
    int                         cfg_writes = 0;
    int                         mismatches = 0;

    point_in_polytope_test_unit #(
        .MAX_DIM    (MAX_DIM),
        .MAX_PLANES (MAX_PLANES)
    ) i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #500ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // first plane with a*y - b strictly above zero
    function automatic verdict_t classify_point();
        verdict_t v;
        int n_dims;
        int n_planes;
        longint acc;
        v = '{outside: 1'b0, plane: '0};
        n_dims = (dims_reg > MAX_DIM) ? MAX_DIM : int'(dims_reg);
        n_planes = (planes_reg > MAX_PLANES) ? MAX_PLANES : int'(planes_reg);
        for (int p = 0; p < n_planes; p++)
        begin
            acc = -(longint'(offset_tab[p]) <<< FRAC_W);
            for (int k = 0; k < n_dims; k++)
                acc += longint'(coef_tab[p * MAX_DIM + k]) * longint'(point_buf[k]);
            if (acc > 0)
            begin
                v.outside = 1'b1;
                v.plane = 8'(p);
                break;
            end
        end
        return v;
    endfunction

    function automatic logic signed [VALUE_W-1:0] any_value();
        case ($urandom_range(7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] near_zero(int bits);
        int span;
        span = 1 << bits;
        return 24'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic signed [VALUE_W-1:0] data_value(value_mix_t mix, int wide_pct);
        if (mix == MIX_FULL || $urandom_range(99) < wide_pct)
            return any_value();
        return near_zero(12);
    endfunction

    // mostly slack planes, a few tight ones
    function automatic logic signed [VALUE_W-1:0] offset_value(value_mix_t mix, int tight_pct);
        if (mix == MIX_FULL)
            return any_value();
        if ($urandom_range(99) < tight_pct)
            return near_zero(11);
        return 24'($urandom_range(24'h7FFFFF, 1 << 14));
    endfunction

    task automatic queue_request(req_t kind, logic [PLANE_IDX_W-1:0] plane,
                                 logic [COORD_IDX_W-1:0] coord,
                                 logic signed [VALUE_W-1:0] val, logic last);
        request_t r;
        r = '{kind: kind, plane: plane, coord: coord, val: val, last: last};
        request_q.push_back(r);
        case (kind)
            REQ_COEF:   coef_loaded[int'(plane) * MAX_DIM + int'(coord)] = 1'b1;
            REQ_OFFSET: offset_loaded[plane] = 1'b1;
            REQ_POINT:  coord_loaded[coord] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic two_coord_point(logic signed [VALUE_W-1:0] y0,
                                   logic signed [VALUE_W-1:0] y1);
        queue_request(REQ_POINT, 8'd0, 3'd0, y0, 1'b0);
        queue_request(REQ_POINT, 8'd0, 3'd1, y1, 1'b1);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        int seen;
        @(negedge clk);
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(negedge clk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [DIM_CFG_W-1:0] dims_cfg, logic [PCNT_CFG_W-1:0] planes_cfg,
                             value_mix_t mix, int tight_pct, bit refresh, bit no_gaps,
                             int points);
        int n_dims;
        int n_planes;
        int coords[$];
        int start;
        int plane;
        wait_idle();
        in_gap_pct = no_gaps ? 0 : IDLE_PCT;
        out_gap_pct = no_gaps ? 0 : IDLE_PCT;
        write_reg(CFG_DIMENSIONS, {5'($urandom), dims_cfg});
        write_reg(CFG_PLANE_COUNT, planes_cfg);
        n_dims = (dims_cfg > MAX_DIM) ? MAX_DIM : int'(dims_cfg);
        n_planes = (planes_cfg > MAX_PLANES) ? MAX_PLANES : int'(planes_cfg);

        // every entry a test can read is loaded before the first point
        for (int p = 0; p < n_planes; p++)
        begin
            if (refresh || !offset_loaded[p])
                queue_request(REQ_OFFSET, 8'(p), 3'($urandom), offset_value(mix, tight_pct),
                              1'($urandom));
            for (int k = 0; k < n_dims; k++)
                if (refresh || !coef_loaded[p * MAX_DIM + k])
                    queue_request(REQ_COEF, 8'(p), 3'(k), data_value(mix, 5), 1'($urandom));
        end

        repeat (points)
        begin
            if ($urandom_range(99) < 8)
                queue_request(REQ_NONE, 8'($urandom), 3'($urandom), 24'($urandom),
                              1'($urandom));
            if ($urandom_range(99) < 25)
            begin
                plane = (n_planes == 0 || $urandom_range(99) < 20) ?
                        int'($urandom_range(MAX_PLANES - 1)) :
                        int'($urandom_range(n_planes - 1));
                if ($urandom_range(1) != 0)
                    queue_request(REQ_COEF, 8'(plane), 3'($urandom), data_value(mix, 5),
                                  1'($urandom));
                else
                    queue_request(REQ_OFFSET, 8'(plane), 3'($urandom),
                                  offset_value(mix, tight_pct), 1'($urandom));
            end

            coords.delete();
            for (int k = 0; k < n_dims; k++)
                if (!coord_loaded[k] || $urandom_range(99) < 70)
                    coords.push_back(k);
            if (n_dims < MAX_DIM && $urandom_range(99) < 15)
                coords.push_back(int'($urandom_range(MAX_DIM - 1, n_dims)));
            if (coords.size() == 0)
                coords.push_back(int'($urandom_range(MAX_DIM - 1)));
            start = int'($urandom_range(coords.size() - 1));
            for (int i = 0; i < coords.size(); i++)
                queue_request(REQ_POINT, 8'($urandom), 3'(coords[(start + i) % coords.size()]),
                              data_value(mix, 10), i == coords.size() - 1);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin : drive_requests
        request_t r;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= in_gap_pct)
            begin
                r = request_q.pop_front();
                in_valid <= 1'b1;
                req_type <= r.kind;
                plane_index <= r.plane;
                coord_index <= r.coord;
                value <= r.val;
                last_coord <= r.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver, with one long stall once results are flowing
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && verdicts_seen >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_gap_pct);
    end

    // monitor: tracks accepted items and checks results
    always @(posedge clk)
    begin : watch_ports
        verdict_t want;
        in_fire = rst_n && in_valid && in_ready;
        if (!rst_n)
        begin
            dims_reg = 4'd1;
            planes_reg = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_reg_t'(cfg_index) == CFG_DIMENSIONS)
                    dims_reg = cfg_data[DIM_CFG_W-1:0];
                else
                    planes_reg = cfg_data[PCNT_CFG_W-1:0];
                cfg_writes++;
            end
            if (in_fire)
            begin
                case (req_t'(req_type))
                    REQ_COEF:   coef_tab[int'(plane_index) * MAX_DIM + int'(coord_index)] = value;
                    REQ_OFFSET: offset_tab[plane_index] = value;
                    REQ_POINT:
                    begin
                        point_buf[coord_index] = value;
                        if (last_coord)
                            verdict_q.push_back(classify_point());
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                verdicts_seen++;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result, outside %0b violating_plane %0d",
                             $time, outside, violating_plane);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (outside !== want.outside)
                    begin
                        $display("%0t: outside expected %0b actual %0b",
                                 $time, want.outside, outside);
                        mismatches++;
                    end
                    if (violating_plane !== want.plane)
                    begin
                        $display("%0t: violating_plane expected %0d actual %0d",
                                 $time, want.plane, violating_plane);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray request code, then a point with no planes in use
        queue_request(REQ_NONE, 8'hFF, 3'd7, VALUE_MIN, 1'b1);
        queue_request(REQ_POINT, 8'hFF, 3'd0, VALUE_MAX, 1'b1);
        wait_idle();
        write_reg(CFG_DIMENSIONS, 9'd2);
        write_reg(CFG_PLANE_COUNT, 9'd3);

        // y0 <= 2, y1 >= 0, and a plane at the value extremes
        queue_request(REQ_COEF, 8'd0, 3'd0, ONE, 1'b1);
        queue_request(REQ_COEF, 8'd0, 3'd1, '0, 1'b0);
        queue_request(REQ_OFFSET, 8'd0, 3'd0, 24'(2 * ONE), 1'b0);
        queue_request(REQ_COEF, 8'd1, 3'd0, '0, 1'b0);
        queue_request(REQ_COEF, 8'd1, 3'd1, -ONE, 1'b0);
        queue_request(REQ_OFFSET, 8'd1, 3'd0, '0, 1'b1);
        queue_request(REQ_COEF, 8'd2, 3'd0, VALUE_MIN, 1'b0);
        queue_request(REQ_COEF, 8'd2, 3'd1, VALUE_MAX, 1'b0);
        queue_request(REQ_OFFSET, 8'd2, 3'd0, VALUE_MIN, 1'b0);

        // on two boundaries at once, just past one, just past another, far out
        two_coord_point(24'(2 * ONE), '0);
        two_coord_point(24'(2 * ONE + 1), '0);
        two_coord_point('0, -24'sd1);
        two_coord_point(VALUE_MIN, VALUE_MAX);

        // zero dimensions: only the offsets decide
        wait_idle();
        write_reg(CFG_DIMENSIONS, 9'd0);
        queue_request(REQ_POINT, 8'd0, 3'd5, any_value(), 1'b1);

        run_phase(4'd1,  9'd511, MIX_NARROW, 2,  1'b1, 1'b0, 12);
        run_phase(4'd0,  9'd256, MIX_NARROW, 2,  1'b0, 1'b0, 14);
        run_phase(4'd3,  9'd16,  MIX_NARROW, 15, 1'b1, 1'b0, 40);
        run_phase(4'd8,  9'd20,  MIX_NARROW, 10, 1'b1, 1'b0, 15);
        run_phase(4'd15, 9'd8,   MIX_FULL,   0,  1'b0, 1'b1, 15);
        run_phase(4'd5,  9'd1,   MIX_FULL,   0,  1'b0, 1'b0, 20);
        run_phase(4'd2,  9'd0,   MIX_FULL,   0,  1'b0, 1'b0, 10);
        run_phase(4'd4,  9'd64,  MIX_FULL,   0,  1'b0, 1'b0, 20);
        run_phase(4'd6,  9'd24,  MIX_NARROW, 10, 1'b0, 1'b0, 20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* point_in_polytope_test_unit.f */
rtl/core/pipt_pkg.sv
rtl/core/point_in_polytope_test_unit.sv
test/tb_point_in_polytope_test_unit.sv
